// ===== src/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// shared types, constants and helpers of the integer to ascii converter
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    // conversion cell chain
    localparam int DIG_N   = 10;             // bcd digit cells
    localparam int SHIFT_W = 3;              // bits shifted through the chain per cycle
    localparam int STEP_N  = 11;             // shift steps per value
    localparam int MAG_W   = SHIFT_W * STEP_N;
    localparam int CNT_W   = $clog2(STEP_N);
    localparam int POS_W   = $clog2(DIG_N);

    // operation codes
    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    // ascii codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_A     = 8'h41;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_DONE
    } cv_state_t;

    typedef enum logic [2:0] {
        EM_IDLE,
        EM_SIGN,
        EM_ZERO,
        EM_X,
        EM_DIGIT
    } em_state_t;

    // finished conversion handed from the cell chain to the emitter
    typedef struct packed {
        logic [DIG_N-1:0][3:0] digits;
        logic                  neg;
        logic                  hex;
    } cv_res_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = CH_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/int_to_ascii_dec_hex_top.sv =====
// Converts a signed 32-bit value to ASCII text, one character per output
// transaction, most significant first, with tlast on the final character.
// tuser selects decimal (0) or hexadecimal with a "0x" prefix and uppercase
// digits (1); negative values are written as '-' and the magnitude, leading
// zeros are dropped. Each value is converted in the digit cell chain
// (11 steps of three bits through ten shift-and-add-3 cells, then the handoff),
// and its 1 to 11 characters leave while the next value converts, so a new
// value is taken before the previous text is finished; a stalled output side
// holds the handoff until the last character of that text enters the output register.
// ----------------------------------------------------------------------------
// int_to_ascii_dec_hex_top
// signed integer to decimal or hexadecimal ascii text converter
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_ascii_dec_hex_top
    import i2a_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] value
    input  wire logic        s_tuser,    // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] character
    output logic             m_tlast
);

    logic    up_valid;
    logic    up_ready;
    cv_res_t up_res;

    i2a_conv u_conv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .up_valid (up_valid),
        .up_ready (up_ready),
        .up_res   (up_res)
    );

    i2a_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (up_valid),
        .up_ready (up_ready),
        .up_res   (up_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== src/i2a_cell.sv =====
// ----------------------------------------------------------------------------
// i2a_cell
// one digit cell of the conversion chain: shift-and-add-3 on a 4-bit digit
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_cell
    import i2a_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               clear,
    input  wire logic               shift,
    input  wire logic               adjust,
    input  wire logic [SHIFT_W-1:0] shin,    // msb is shifted in first
    output logic      [SHIFT_W-1:0] shout,   // to the next cell, msb first
    output logic      [3:0]         digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] shifted;

    always_comb
    begin
        logic [3:0] d;
        logic [3:0] a;
        d = digit_reg;
        shout = '0;
        for (int k = SHIFT_W - 1; k >= 0; k--)
        begin
            // decimal correction before each shift keeps the digit in bcd range
            a = (adjust && d >= 4'd5) ? d + 4'd3 : d;
            shout[k] = a[3];
            d = {a[2:0], shin[k]};
        end
        shifted = d;
    end

    always_comb
    begin
        if (clear)
        begin
            digit_next = '0;
        end
        else if (shift)
        begin
            digit_next = shifted;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

`default_nettype wire

// ===== src/i2a_conv.sv =====
// ----------------------------------------------------------------------------
// i2a_conv
// input side: magnitude shift register driving a chain of digit cells
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_conv
    import i2a_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // value
    input  wire logic        s_tuser,    // operation
    output logic             up_valid,
    input  wire logic        up_ready,
    output cv_res_t          up_res
);

    cv_state_t        state_reg;
    cv_state_t        state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    logic             hex_reg;

    logic             accept;
    logic             clear;
    logic             shift;
    logic [31:0]      mag_in;

    logic [DIG_N:0][SHIFT_W-1:0] carry;
    logic [DIG_N-1:0][3:0]       digits;

    assign accept = s_tvalid && s_tready;
    assign mag_in = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CV_IDLE:
            begin
                if (accept)
                begin
                    state_next = CV_RUN;
                end
            end
            CV_RUN:
            begin
                if (cnt_reg == CNT_W'(STEP_N - 1))
                begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE:
            begin
                if (up_ready)
                begin
                    state_next = accept ? CV_RUN : CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        shift    = 1'b0;
        up_valid = 1'b0;
        case (state_reg)
            CV_IDLE:
            begin
                s_tready = 1'b1;
            end
            CV_RUN:
            begin
                shift = 1'b1;
            end
            CV_DONE:
            begin
                up_valid = 1'b1;
                s_tready = up_ready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign clear    = accept;
    assign cnt_next = accept ? '0 : (shift ? cnt_reg + 1'b1 : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg <= {{(MAG_W - 32){1'b0}}, mag_in};
            neg_reg <= s_tdata[31];
            hex_reg <= (s_tuser == OP_HEX);
        end
        else if (shift)
        begin
            mag_reg <= {mag_reg[MAG_W-SHIFT_W-1:0], {SHIFT_W{1'b0}}};
        end
    end

    assign carry[0] = mag_reg[MAG_W-1 -: SHIFT_W];

    for (genvar i = 0; i < DIG_N; i++)
    begin : g_cell
        i2a_cell u_cell
        (
            .clk    (clk),
            .clear  (clear),
            .shift  (shift),
            .adjust (!hex_reg),
            .shin   (carry[i]),
            .shout  (carry[i+1]),
            .digit  (digits[i])
        );
    end

    assign up_res.digits = digits;
    assign up_res.neg    = neg_reg;
    assign up_res.hex    = hex_reg;

`ifndef SYNTHESIS
    logic bcd_ok;

    always_comb
    begin
        bcd_ok = 1'b1;
        for (int i = 0; i < DIG_N; i++)
        begin
            if (digits[i] > 4'd9)
            begin
                bcd_ok = 1'b0;
            end
        end
    end

    // the chain is wide enough for a 32-bit magnitude
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CV_RUN |-> carry[DIG_N] == '0)
        else $error("digit chain overflow");

    // every decimal result is valid bcd
    a_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CV_DONE && !hex_reg |-> bcd_ok)
        else $error("decimal digit out of range");

    // a new value always starts the shift sequence from step zero
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == CV_RUN && cnt_reg == '0)
        else $error("conversion did not start");
`endif

endmodule

`default_nettype wire

// ===== src/i2a_emit.sv =====
// ----------------------------------------------------------------------------
// i2a_emit
// output side: sign, prefix and digit sequencer with an output register
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_emit
    import i2a_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       up_valid,
    output logic            up_ready,
    input  wire cv_res_t    up_res,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // character
    output logic            m_tlast     // last
);

    em_state_t             state_reg;
    em_state_t             state_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [DIG_N-1:0][3:0] digits_reg;
    logic                  hex_reg;

    logic                  m_tvalid_reg;
    logic [7:0]            m_tdata_reg;
    logic                  m_tlast_reg;

    logic                  adv;
    logic                  load;
    logic                  emit_en;
    logic [7:0]            char_sel;
    logic                  last_sel;
    logic [POS_W-1:0]      top_pos;
    em_state_t             load_state;

    // output register free or draining this cycle
    assign adv  = !m_tvalid_reg || m_tready;
    assign load = up_valid && up_ready;

    // highest nonzero digit, at least one digit
    always_comb
    begin
        top_pos = '0;
        for (int i = 1; i < DIG_N; i++)
        begin
            if (up_res.digits[i] != 4'd0)
            begin
                top_pos = POS_W'(i);
            end
        end
    end

    assign load_state = up_res.neg ? EM_SIGN : (up_res.hex ? EM_ZERO : EM_DIGIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            EM_IDLE:
            begin
                if (load)
                begin
                    state_next = load_state;
                    pos_next   = top_pos;
                end
            end
            EM_SIGN:
            begin
                if (adv)
                begin
                    state_next = hex_reg ? EM_ZERO : EM_DIGIT;
                end
            end
            EM_ZERO:
            begin
                if (adv)
                begin
                    state_next = EM_X;
                end
            end
            EM_X:
            begin
                if (adv)
                begin
                    state_next = EM_DIGIT;
                end
            end
            EM_DIGIT:
            begin
                if (adv)
                begin
                    if (pos_reg == '0)
                    begin
                        state_next = load ? load_state : EM_IDLE;
                        pos_next   = load ? top_pos : pos_reg;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        up_ready = 1'b0;
        char_sel = CH_ZERO;
        last_sel = 1'b0;
        case (state_reg)
            EM_IDLE:
            begin
                up_ready = 1'b1;
            end
            EM_SIGN:
            begin
                char_sel = CH_MINUS;
            end
            EM_ZERO:
            begin
                char_sel = CH_ZERO;
            end
            EM_X:
            begin
                char_sel = CH_X;
            end
            EM_DIGIT:
            begin
                char_sel = digit_char(digits_reg[pos_reg]);
                last_sel = (pos_reg == '0);
                up_ready = (pos_reg == '0) && adv;
            end
            default:
            begin
                up_ready = 1'b0;
            end
        endcase
    end

    assign emit_en = adv && (state_reg != EM_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= EM_IDLE;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (adv)
            begin
                m_tvalid_reg <= emit_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digits_reg <= up_res.digits;
            hex_reg    <= up_res.hex;
        end
        if (emit_en)
        begin
            m_tdata_reg <= char_sel;
            m_tlast_reg <= last_sel;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // a loaded value always produces characters
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> state_reg != EM_IDLE)
        else $error("value loaded but emitter idle");

    // the prefix only appears on hexadecimal text
    a_prefix_hex: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EM_ZERO || state_reg == EM_X) |-> hex_reg)
        else $error("hex prefix on decimal text");

    // a new value is only taken once the previous text is finished
    a_load_end: assert property (@(posedge clk) disable iff (!rst_n)
        load && state_reg == EM_DIGIT |-> emit_en && last_sel)
        else $error("value loaded before text finished");
`endif

endmodule

`default_nettype wire
